>>> rtl/core/assert_macros.svh
// Assertion macros shared by the matrix multiply engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define MME_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mme_pkg.sv
// Types, sizes and codes shared by the matrix multiply engine modules.
package mme_pkg;

	// store sizes
	localparam int MAX_ROWS   = 32;
	localparam int MAX_SHARED = 32;
	localparam int MAX_COLS   = 32;

	localparam int A_DEPTH = MAX_ROWS * MAX_SHARED;
	localparam int B_DEPTH = MAX_SHARED * MAX_COLS;
	localparam int A_AW    = $clog2(A_DEPTH);
	localparam int B_AW    = $clog2(B_DEPTH);

	// columns per row are also capped by the 5-bit column field
	localparam int COL_LIM = (MAX_COLS < 32) ? MAX_COLS : 32;

	// counter widths, wide enough to hold the limit itself
	localparam int R_W = $clog2(MAX_ROWS + 1);
	localparam int K_W = $clog2(MAX_SHARED + 1);
	localparam int J_W = $clog2(COL_LIM + 1);

	// field widths
	localparam int MODE_W    = 2;
	localparam int IDX_W     = 5;
	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int SUM_W     = 37;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 2;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_PAD_W    = IN_TDATA_W - 2 * IDX_W - ELEM_W;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - IDX_W;

	// request kinds
	localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_FLUSH,
		ST_PUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             clr;
		logic             issue;
		logic             push;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [K_W-1:0]   k;
		logic [J_W-1:0]   col;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/core/mme_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/mme_datapath.sv
// Element stores, multiply-accumulate pipeline and output register.
module mme_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mme_pkg::ctl_cmd_t             cmd,
	output mme_pkg::dp_stat_t             stat,
	input  logic [mme_pkg::IDX_W-1:0]     first_index,
	input  logic [mme_pkg::IDX_W-1:0]     second_index,
	input  logic signed [mme_pkg::ELEM_W-1:0] element,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [mme_pkg::SUM_W-1:0] out_sum,
	output logic [mme_pkg::IDX_W-1:0]     out_column,
	output logic                          out_last
);

	logic [mme_pkg::A_AW-1:0] a_waddr, a_raddr;
	logic [mme_pkg::B_AW-1:0] b_waddr, b_raddr;
	logic [mme_pkg::ELEM_W-1:0] a_rdata, b_rdata;

	logic                               valid_s1;
	logic                               valid_s2;
	logic signed [mme_pkg::PROD_W-1:0]  prod_s2;
	logic signed [mme_pkg::SUM_W-1:0]   acc_q;

	logic                               out_valid_q;
	logic signed [mme_pkg::SUM_W-1:0]   sum_q;
	logic [mme_pkg::IDX_W-1:0]          column_q;
	logic                               last_q;

	// row-major addressing
	assign a_waddr = mme_pkg::A_AW'(32'(first_index) * mme_pkg::MAX_SHARED
		+ 32'(second_index));
	assign b_waddr = mme_pkg::B_AW'(32'(first_index) * mme_pkg::MAX_COLS
		+ 32'(second_index));
	assign a_raddr = mme_pkg::A_AW'(32'(cmd.row) * mme_pkg::MAX_SHARED + 32'(cmd.k));
	assign b_raddr = mme_pkg::B_AW'(32'(cmd.k) * mme_pkg::MAX_COLS + 32'(cmd.col));

	mme_ram #(
		.WIDTH(mme_pkg::ELEM_W),
		.DEPTH(mme_pkg::A_DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (cmd.wr_a),
		.waddr(a_waddr),
		.wdata(element),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	mme_ram #(
		.WIDTH(mme_pkg::ELEM_W),
		.DEPTH(mme_pkg::B_DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (cmd.wr_b),
		.waddr(b_waddr),
		.wdata(element),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// product is exact Q15.16
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		end
	end

	// Q20.16 accumulator, wraps modulo 2^37
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + mme_pkg::SUM_W'(prod_s2);
		end
	end

	assign stat.busy     = valid_s1 | valid_s2;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			sum_q    <= acc_q;
			column_q <= mme_pkg::IDX_W'(cmd.col);
			last_q   <= cmd.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sum    = sum_q;
	assign out_column = column_q;
	assign out_last   = last_q;

endmodule

>>> rtl/core/mme_controller.sv
// Sequencer: configuration registers and the row/column/shared walk.
module mme_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mme_pkg::MODE_W-1:0]    mode,
	input  logic [mme_pkg::IDX_W-1:0]     first_index,
	input  logic [mme_pkg::IDX_W-1:0]     second_index,
	input  logic                          cfg_valid,
	input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]     cfg_data,
	output mme_pkg::ctl_cmd_t             cmd,
	input  mme_pkg::dp_stat_t             stat
);

	mme_pkg::state_t state_q, state_d;

	logic [mme_pkg::CFG_W-1:0] rows_q, shared_q, cols_q;
	logic [mme_pkg::R_W-1:0]   rows_eff;
	logic [mme_pkg::K_W-1:0]   shared_eff;
	logic [mme_pkg::J_W-1:0]   cols_eff;

	logic [mme_pkg::IDX_W-1:0] row_q;
	logic [mme_pkg::K_W-1:0]   k_q;
	logic [mme_pkg::J_W-1:0]   j_q;

	logic accept;
	logic start;
	logic mac_done;
	logic col_last;

	// register writes; indexes past the list fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= mme_pkg::CFG_RESET;
			shared_q <= mme_pkg::CFG_RESET;
			cols_q   <= mme_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mme_pkg::CFG_ROWS:   rows_q   <= cfg_data;
				mme_pkg::CFG_SHARED: shared_q <= cfg_data;
				mme_pkg::CFG_COLS:   cols_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate to store sizes
	assign rows_eff = (32'(rows_q) > mme_pkg::MAX_ROWS) ?
		mme_pkg::R_W'(mme_pkg::MAX_ROWS) : mme_pkg::R_W'(rows_q);
	assign shared_eff = (32'(shared_q) > mme_pkg::MAX_SHARED) ?
		mme_pkg::K_W'(mme_pkg::MAX_SHARED) : mme_pkg::K_W'(shared_q);
	assign cols_eff = (32'(cols_q) > mme_pkg::COL_LIM) ?
		mme_pkg::J_W'(mme_pkg::COL_LIM) : mme_pkg::J_W'(cols_q);

	assign in_ready = (state_q == mme_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign start    = accept && (mode == mme_pkg::MODE_COMPUTE)
		&& (32'(first_index) < 32'(rows_eff)) && (cols_eff != '0);
	assign mac_done = (k_q + mme_pkg::K_W'(1)) >= shared_eff;
	assign col_last = (j_q + mme_pkg::J_W'(1)) == cols_eff;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mme_pkg::ST_MAC;
				end
			end
			mme_pkg::ST_MAC: begin
				if (mac_done || shared_eff == '0) begin
					state_d = mme_pkg::ST_FLUSH;
				end
			end
			mme_pkg::ST_FLUSH: begin
				if (!stat.busy) begin
					state_d = mme_pkg::ST_PUSH;
				end
			end
			mme_pkg::ST_PUSH: begin
				if (stat.out_free) begin
					state_d = col_last ? mme_pkg::ST_IDLE : mme_pkg::ST_MAC;
				end
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		cmd.row   = row_q;
		cmd.k     = k_q;
		cmd.col   = j_q;
		cmd.last  = col_last;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				cmd.wr_a = accept && (mode == mme_pkg::MODE_LOAD_A)
					&& (32'(first_index) < mme_pkg::MAX_ROWS)
					&& (32'(second_index) < mme_pkg::MAX_SHARED);
				cmd.wr_b = accept && (mode == mme_pkg::MODE_LOAD_B)
					&& (32'(first_index) < mme_pkg::MAX_SHARED)
					&& (32'(second_index) < mme_pkg::MAX_COLS);
				cmd.clr  = start;
			end
			mme_pkg::ST_MAC: begin
				cmd.issue = k_q < shared_eff;
			end
			mme_pkg::ST_FLUSH: ;
			mme_pkg::ST_PUSH: begin
				cmd.push = stat.out_free;
				cmd.clr  = stat.out_free && !col_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			row_q   <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				row_q <= first_index;
				j_q   <= '0;
			end else if (cmd.push && !col_last) begin
				j_q <= j_q + mme_pkg::J_W'(1);
			end
			if (cmd.clr) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + mme_pkg::K_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/matrix_multiply_engine.sv
// Matrix multiply engine (GEMM): A and B element stores, one result row per compute
// request. Load requests (tuser mode 0 for A, 1 for B) write one signed Q7.8 element
// and the next request can follow at once; loads past the store size are dropped. A
// compute request (mode 2) for row i walks every column j below cols_in_use and, for
// each, streams the dot product of A row i with B column j as an exact Q20.16 sum (37
// bits, wrapping, never saturating), with tlast on the final column. Rows at or beyond
// rows_in_use, mode 3 and an empty column count give no output. All work goes through
// a single shared multiply-accumulate fed by two 1024-entry RAMs with registered
// reads: each column issues shared_in_use reads, both sizes taken after saturation,
// then waits for the pipeline to drain and for room in the output register, so a
// sink stall holds the walk. One result sits in the output register while the next
// column is being accumulated. New requests are taken only between rows. Registers
// may be written only while the engine is idle; the write channel is always ready.
// Store contents are undefined until loaded.
`include "assert_macros.svh"

module matrix_multiply_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// request stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [4:0] first_index, [9:5] second_index, [25:10] element, [31:26] zero
	input  logic [mme_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// [1:0] mode
	input  logic [mme_pkg::MODE_W-1:0]            s_axis_tuser,

	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [36:0] sum, [41:37] column, [47:42] zero
	output logic [mme_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	output logic                                  m_axis_tlast,

	// register write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mme_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]             cfg_data
);

	mme_pkg::ctl_cmd_t cmd;
	mme_pkg::dp_stat_t stat;

	logic [mme_pkg::IDX_W-1:0]          first_index;
	logic [mme_pkg::IDX_W-1:0]          second_index;
	logic signed [mme_pkg::ELEM_W-1:0]  element;
	logic signed [mme_pkg::SUM_W-1:0]   out_sum;
	logic [mme_pkg::IDX_W-1:0]          out_column;

	// unpack request
	assign first_index  = s_axis_tdata[mme_pkg::IDX_W-1:0];
	assign second_index = s_axis_tdata[2*mme_pkg::IDX_W-1:mme_pkg::IDX_W];
	assign element      = s_axis_tdata[2*mme_pkg::IDX_W+mme_pkg::ELEM_W-1:2*mme_pkg::IDX_W];

	// config changes must come only between requests; the block itself does not enforce it
	assign cfg_ready = 1'b1;

	mme_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.mode        (s_axis_tuser),
		.first_index (first_index),
		.second_index(second_index),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat)
	);

	mme_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.first_index (first_index),
		.second_index(second_index),
		.element     (element),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_sum     (out_sum),
		.out_column  (out_column),
		.out_last    (m_axis_tlast)
	);

	// pack result
	assign m_axis_tdata = {{mme_pkg::OUT_PAD_W{1'b0}}, out_column, out_sum};

	// a result is only handed over once the accumulator has settled and there is room
	`MME_ASSERT_IMP(a_push_settled, cmd.push, stat.out_free && !stat.busy, "push while busy or full")
	// the accumulator is never cleared under in-flight products
	`MME_ASSERT_IMP(a_clr_quiet, cmd.clr, !stat.busy, "accumulator cleared mid-run")
	// taking requests means the MAC pipeline has drained
	`MME_ASSERT_IMP(a_idle_empty, s_axis_tready, !stat.busy, "idle with products in flight")
	// a read issue always lands in the pipeline
	`MME_ASSERT_NXT(a_issue_tracked, cmd.issue, stat.busy, "issued read not tracked")

endmodule

>>> test/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply engine: loads, row computes, register edges.
module tb_matrix_multiply_engine;
	import mme_pkg::*;

	localparam int CLK_NS         = 12;
	localparam int TIMEOUT_CYCLES = 20_000_000;
	localparam int SETTLE_CYCLES  = 16;   // an empty row or a load is done well within this
	localparam int RANDOM_TARGET  = 400;

	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

	localparam logic signed [ELEM_W-1:0] ELEM_MIN  = 16'sh8000;
	localparam logic signed [ELEM_W-1:0] ELEM_MAX  = 16'sh7FFF;
	localparam logic signed [ELEM_W-1:0] ELEM_ONE  = 16'sh0100;   // 1.0 in Q7.8
	localparam logic signed [ELEM_W-1:0] ELEM_TINY = 16'sh0001;

	// one expected dot product
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [IDX_W-1:0]        column;
		logic                    last;
	} row_sum_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [MODE_W-1:0]      s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	// shadow of the engine: element stores, which entries hold data, registers
	logic signed [ELEM_W-1:0] a_elem [MAX_ROWS][MAX_SHARED];
	logic signed [ELEM_W-1:0] b_elem [MAX_SHARED][MAX_COLS];
	bit                       a_known [MAX_ROWS][MAX_SHARED];
	bit                       b_known [MAX_SHARED][MAX_COLS];
	logic [CFG_W-1:0]         rows_reg;
	logic [CFG_W-1:0]         shared_reg;
	logic [CFG_W-1:0]         cols_reg;

	row_sum_t pending_sums [$];

	int error_count;
	int requests_sent;
	int computes_sent;
	int sums_checked;
	int send_calm;
	int sink_calm;
	int sink_stall;

	matrix_multiply_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_NS / 2.0) clk = ~clk;
	end

	initial begin
		#(CLK_NS * TIMEOUT_CYCLES);
		$display("%0t ns: timed out, %0d sums still expected", $time, pending_sums.size());
		$display("TEST FAILED");
		$finish;
	end

	// Gap picker shared by both sides: mostly none, some short, a few long, and now and
	// then a calm stretch with no gaps at all.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int capped(input int v, input int lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic int rows_now();
		return capped(rows_reg, MAX_ROWS);
	endfunction

	function automatic int shared_now();
		return capped(shared_reg, MAX_SHARED);
	endfunction

	function automatic int cols_now();
		return capped(capped(cols_reg, MAX_COLS), 32);
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return '0;
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	// Expected sums of one result row: exact products, summed from zero, kept to 37 bits.
	function automatic void predict_row_sums(input logic [IDX_W-1:0] row);
		int       shared;
		int       cols;
		longint   acc;
		row_sum_t r;
		shared = shared_now();
		cols   = cols_now();
		if (row >= rows_now() || cols == 0) return;
		for (int j = 0; j < cols; j++) begin
			acc = 0;
			for (int k = 0; k < shared; k++)
				acc += longint'(a_elem[row][k]) * longint'(b_elem[k][j]);
			r.sum    = acc[SUM_W-1:0];
			r.column = j[IDX_W-1:0];
			r.last   = (j == cols - 1);
			pending_sums.push_back(r);
		end
	endfunction

	function automatic void track_request(input logic [MODE_W-1:0] mode,
			input logic [IDX_W-1:0] first_idx, input logic [IDX_W-1:0] second_idx,
			input logic signed [ELEM_W-1:0] element);
		case (mode)
			MODE_LOAD_A: begin
				if (first_idx < MAX_ROWS && second_idx < MAX_SHARED) begin
					a_elem[first_idx][second_idx]  = element;
					a_known[first_idx][second_idx] = 1'b1;
				end
			end
			MODE_LOAD_B: begin
				if (first_idx < MAX_SHARED && second_idx < MAX_COLS) begin
					b_elem[first_idx][second_idx]  = element;
					b_known[first_idx][second_idx] = 1'b1;
				end
			end
			MODE_COMPUTE: begin
				predict_row_sums(first_idx);
				computes_sent++;
			end
			default: ;
		endcase
	endfunction

	// Stimulus tasks all start and end just after a falling edge.
	task automatic send_request(input logic [MODE_W-1:0] mode,
			input logic [IDX_W-1:0] first_idx, input logic [IDX_W-1:0] second_idx,
			input logic signed [ELEM_W-1:0] element);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {{IN_PAD_W{1'b0}}, element, second_idx, first_idx};
		s_axis_tuser  = mode;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// expectations go in at the falling edge after acceptance, well before any result can follow
		@(negedge clk);
		track_request(mode, first_idx, second_idx, element);
		if (mode != MODE_UNUSED) requests_sent++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_index = idx;
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			CFG_ROWS:   rows_reg   = value;
			CFG_SHARED: shared_reg = value;
			CFG_COLS:   cols_reg   = value;
			default: ;
		endcase
	endtask

	// Hold off until every expected sum is back and the engine has settled.
	task automatic wait_until_drained();
		s_axis_tvalid = 1'b0;
		while (pending_sums.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] shared,
			input logic [CFG_W-1:0] cols);
		wait_until_drained();
		write_register(CFG_ROWS, rows);
		write_register(CFG_SHARED, shared);
		write_register(CFG_COLS, cols);
	endtask

	// Load whatever a compute of this row would read that has never been written.
	task automatic fill_for_row(input logic [IDX_W-1:0] row);
		int shared;
		int cols;
		shared = shared_now();
		cols   = cols_now();
		if (row >= rows_now() || cols == 0) return;
		for (int k = 0; k < shared; k++)
			if (!a_known[row][k])
				send_request(MODE_LOAD_A, row, IDX_W'(k), pick_element());
		for (int k = 0; k < shared; k++)
			for (int j = 0; j < cols; j++)
				if (!b_known[k][j])
					send_request(MODE_LOAD_B, IDX_W'(k), IDX_W'(j), pick_element());
	endtask

	// Reset sizes (32 x 32 x 32) with extreme operands: largest positive and negative sums.
	task automatic test_reset_size();
		for (int k = 0; k < MAX_SHARED; k++) begin
			send_request(MODE_LOAD_A, '0, IDX_W'(k), ELEM_MIN);
			send_request(MODE_LOAD_A, '1, IDX_W'(k), ELEM_MAX);
		end
		for (int k = 0; k < MAX_SHARED; k++)
			for (int j = 0; j < MAX_COLS; j++)
				send_request(MODE_LOAD_B, IDX_W'(k), IDX_W'(j), j[0] ? ELEM_MAX : ELEM_MIN);
		send_request(MODE_COMPUTE, '0, '1, ELEM_MAX);
		send_request(MODE_COMPUTE, '1, '0, ELEM_MIN);
		wait_until_drained();
	endtask

	// Tiny matrices, edge values, top indexes, rows past the end, the unused mode.
	task automatic test_small_extremes();
		set_sizes(6'd2, 6'd2, 6'd2);
		send_request(MODE_LOAD_A, 5'd0, 5'd1, ELEM_MAX);
		send_request(MODE_LOAD_A, 5'd1, 5'd0, ELEM_TINY);
		send_request(MODE_LOAD_A, 5'd1, 5'd1, -ELEM_TINY);
		send_request(MODE_LOAD_B, 5'd0, 5'd0, ELEM_MIN);
		send_request(MODE_LOAD_B, 5'd1, 5'd0, ELEM_MIN);
		send_request(MODE_LOAD_B, 5'd0, 5'd1, ELEM_MAX);
		send_request(MODE_LOAD_B, 5'd1, 5'd1, ELEM_ONE);
		send_request(MODE_LOAD_A, '1, '1, 16'sh5555);
		send_request(MODE_LOAD_B, '1, '1, 16'shAAAA);
		send_request(MODE_COMPUTE, 5'd0, '0, '0);
		send_request(MODE_COMPUTE, 5'd1, '1, '1);
		// rows past rows_in_use and the spare mode give nothing
		send_request(MODE_COMPUTE, 5'd2, '0, '0);
		send_request(MODE_COMPUTE, '1, '1, ELEM_MIN);
		send_request(MODE_UNUSED, '1, '1, '1);
		send_request(MODE_UNUSED, '0, '0, '0);
		send_request(MODE_COMPUTE, 5'd0, '0, '0);
		wait_until_drained();
	endtask

	// Empty dimensions, the spare register index and saturated register values.
	task automatic test_register_edges();
		set_sizes(6'd0, 6'd4, 6'd4);
		send_request(MODE_COMPUTE, 5'd0, '0, '0);
		set_sizes(6'd3, 6'd4, 6'd0);
		send_request(MODE_COMPUTE, 5'd1, '0, '0);
		// empty shared dimension: zero sums, no store reads
		set_sizes(6'd3, 6'd0, 6'd5);
		send_request(MODE_COMPUTE, 5'd2, '0, '0);
		send_request(MODE_COMPUTE, 5'd3, '0, '0);
		wait_until_drained();
		write_register(CFG_UNUSED, '1);
		send_request(MODE_COMPUTE, 5'd0, '0, '0);
		// values past the store size act as the full size
		set_sizes('1, '1, 6'd33);
		fill_for_row('1);
		send_request(MODE_COMPUTE, '1, '0, '0);
		wait_until_drained();
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)  return '0;
		if (r < 62) return CFG_W'($urandom_range(1, 8));
		if (r < 82) return CFG_W'($urandom_range(9, 31));
		if (r < 94) return CFG_W'(32);
		return CFG_W'($urandom_range(33, 63));
	endfunction

	// Phases of random sizes; mostly filled rows then computes, with loose loads and noise.
	task automatic test_random_traffic();
		int                start_count;
		int                budget;
		int                r;
		logic [IDX_W-1:0]  row;
		start_count = requests_sent;
		while (requests_sent - start_count < RANDOM_TARGET) begin
			set_sizes(pick_size(), pick_size(), pick_size());
			budget = (shared_now() * cols_now() > 256) ? 4 : 30;
			for (int n = 0; n < budget; n++) begin
				r = $urandom_range(0, 99);
				if (r < 55 || (r >= 88 && r < 95 && rows_now() == MAX_ROWS)) begin
					if (rows_now() == 0)
						row = IDX_W'($urandom_range(0, 31));
					else
						row = IDX_W'($urandom_range(0, rows_now() - 1));
					fill_for_row(row);
					send_request(MODE_COMPUTE, row, IDX_W'($urandom()), pick_element());
				end else if (r < 80) begin
					if ($urandom_range(0, 1))
						send_request(MODE_LOAD_A,
							IDX_W'($urandom_range(0, capped(rows_now(), 32) == 0 ?
								0 : rows_now() - 1)),
							IDX_W'($urandom_range(0, shared_now() == 0 ? 0 : shared_now() - 1)),
							pick_element());
					else
						send_request(MODE_LOAD_B,
							IDX_W'($urandom_range(0, shared_now() == 0 ? 0 : shared_now() - 1)),
							IDX_W'($urandom_range(0, cols_now() == 0 ? 0 : cols_now() - 1)),
							pick_element());
				end else if (r < 88) begin
					// loose load anywhere in either store
					send_request($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A,
						IDX_W'($urandom()), IDX_W'($urandom()), pick_element());
				end else if (r < 95) begin
					send_request(MODE_COMPUTE, IDX_W'($urandom_range(rows_now(), 31)),
						IDX_W'($urandom()), pick_element());
				end else begin
					send_request(MODE_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()),
						pick_element());
				end
			end
		end
		wait_until_drained();
	endtask

	// Result sink: random stalls on tready, one change per falling edge.
	initial begin
		m_axis_tready = 1'b0;
		sink_stall    = 0;
		sink_calm     = 0;
		forever @(negedge clk) begin
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
				sink_stall    = pick_gap(sink_calm);
			end
		end
	end

	// Each accepted result against the oldest expected sum.
	always @(posedge clk) begin
		row_sum_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sums_checked++;
			if (pending_sums.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result, expected none, got sum %0d column %0d last %0b",
					$time, $signed(m_axis_tdata[SUM_W-1:0]),
					m_axis_tdata[SUM_W +: IDX_W], m_axis_tlast);
			end else begin
				want = pending_sums.pop_front();
				if (m_axis_tdata[SUM_W-1:0] !== want.sum) begin
					error_count++;
					$display("%0t ns: sum mismatch (column %0d), expected %0d, got %0d", $time,
						want.column, want.sum, $signed(m_axis_tdata[SUM_W-1:0]));
				end
				if (m_axis_tdata[SUM_W +: IDX_W] !== want.column) begin
					error_count++;
					$display("%0t ns: column mismatch, expected %0d, got %0d", $time,
						want.column, m_axis_tdata[SUM_W +: IDX_W]);
				end
				if (m_axis_tlast !== want.last) begin
					error_count++;
					$display("%0t ns: tlast mismatch (column %0d), expected %0b, got %0b", $time,
						want.column, want.last, m_axis_tlast);
				end
				if (m_axis_tdata[OUT_TDATA_W-1:SUM_W+IDX_W] !== '0) begin
					error_count++;
					$display("%0t ns: tdata padding mismatch, expected 0, got %0h", $time,
						m_axis_tdata[OUT_TDATA_W-1:SUM_W+IDX_W]);
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rows_reg      = CFG_RESET;
		shared_reg    = CFG_RESET;
		cols_reg      = CFG_RESET;
		error_count   = 0;
		requests_sent = 0;
		computes_sent = 0;
		sums_checked  = 0;
		send_calm     = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_size();
		test_small_extremes();
		test_register_edges();
		test_random_traffic();

		wait_until_drained();
		$display("Run covered %0d load/compute requests (%0d row computes) over varied sizes,",
			requests_sent, computes_sent);
		$display("with %0d result sums checked and %0d mismatches.", sums_checked, error_count);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/mme_datapath.sv
rtl/core/mme_controller.sv
rtl/core/matrix_multiply_engine.sv
test/tb_matrix_multiply_engine.sv
